/* rtl/mtt_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtt_pkg
// Shared types, event codes and constants of the markup tag tokenizer.
// ----------------------------------------------------------------------------
package mtt_pkg;

    // Event codes carried on the result stream
    localparam logic [3:0] EV_APPEND       = 4'd0;
    localparam logic [3:0] EV_TEXT_END     = 4'd1;
    localparam logic [3:0] EV_TAG_NAME     = 4'd2;
    localparam logic [3:0] EV_PENDING_NAME = 4'd3;
    localparam logic [3:0] EV_PAIR         = 4'd4;
    localparam logic [3:0] EV_NAME_ONLY    = 4'd5;
    localparam logic [3:0] EV_PENDING_EMPTY = 4'd6;
    localparam logic [3:0] EV_TAG_DONE     = 4'd7;
    localparam logic [3:0] EV_ERROR        = 4'd8;

    // Tag kinds
    localparam logic [1:0] TK_NONE  = 2'd0;
    localparam logic [1:0] TK_OPEN  = 2'd1;
    localparam logic [1:0] TK_CLOSE = 2'd2;
    localparam logic [1:0] TK_SELF  = 2'd3;

    // Error codes
    localparam logic [1:0] ERR_BAD_CHAR    = 2'd0;
    localparam logic [1:0] ERR_BAD_TOKEN   = 2'd1;
    localparam logic [1:0] ERR_NO_TAG_NAME = 2'd2;
    localparam logic [1:0] ERR_CLOSE_ATTRS = 2'd3;

    // Input kinds
    localparam logic KIND_BYTE = 1'b0;
    localparam logic KIND_END  = 1'b1;

    // Results one input word may cause
    localparam int MAX_RES = 4;
    localparam int CNT_W   = $clog2(MAX_RES + 1);
    localparam int SUB_W   = $clog2(MAX_RES);

    // Default depth of the queue between front and back
    localparam int FIFO_DEPTH_DEF = 4;

    typedef struct packed {
        logic       end_seen;
        logic [1:0] error_code;
        logic [1:0] tag_kind;
        logic [7:0] out_byte;
        logic [3:0] event_res;
    } t_evt;

    typedef struct packed {
        logic [CNT_W-1:0]       cnt;
        t_evt [MAX_RES-1:0]     ev;
    } t_bundle;

    typedef struct packed {
        logic full;
        logic empty;
    } t_fifo_st;

    function automatic t_evt mk_evt(logic [3:0] ev, logic [7:0] b, logic [1:0] tk,
                                    logic [1:0] ec, logic endf);
        t_evt e;
        e.event_res  = ev;
        e.out_byte   = b;
        e.tag_kind   = tk;
        e.error_code = ec;
        e.end_seen   = endf;
        return e;
    endfunction

endpackage

/* rtl/markup_tag_tokenizer_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// markup_tag_tokenizer_unit
// Byte-serial markup tokenizer: turns text bytes into tokenizer events.
// ----------------------------------------------------------------------------
//
//  channel   dir  word contents                          handshake
//  s_axis    in   tdata: text_byte; tuser: kind          tvalid/tready
//  m_axis    out  tdata: out_byte,tag_kind,error_code;   tvalid/tready, tlast
//                 tuser: event_res,end_seen
//
//  The front takes one input word per cycle while the queue has room and
//  resolves the whole tokenizer step in that cycle, pushing up to four events
//  as one bundle. The back sends one event per cycle from its output register
//  while the output is ready; the event serializer sets the sustained rate.
//  Events pass through the queue and then the output register. Synchronous
//  active-low reset clears tokenizer state, queue pointers and the output valid
//  flag. Either side may stall freely: the queue absorbs the difference.
//
module markup_tag_tokenizer_unit #(
    parameter int FIFO_DEPTH = mtt_pkg::FIFO_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,  // [7:0] text_byte
    input  logic [0:0]  s_axis_tuser,  // [0] kind
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,  // [7:0] out_byte, [9:8] tag_kind,
                                       // [11:10] error_code, [15:12] zero
    output logic [7:0]  m_axis_tuser,  // [3:0] event_res, [4] end_seen, [7:5] zero
    output logic        m_axis_tlast   // last result of the input word
);
    import mtt_pkg::*;

    t_fifo_st w_fifo_st;
    t_bundle  w_push_data, w_head;
    logic     w_push, w_pop;
    t_evt     w_evt;

    // Front: accept and classify each word
    mtt_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (s_axis_tvalid),
        .o_ready   (s_axis_tready),
        .i_kind    (s_axis_tuser[0]),
        .i_byte    (s_axis_tdata),
        .i_fifo_st (w_fifo_st),
        .o_push    (w_push),
        .o_bundle  (w_push_data)
    );

    // Queue: hold bundles while the output stalls
    mtt_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_wdata (w_push_data),
        .i_pop   (w_pop),
        .o_head  (w_head),
        .o_st    (w_fifo_st)
    );

    // Back: drain one event per cycle while the output is ready
    mtt_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_head    (w_head),
        .i_fifo_st (w_fifo_st),
        .o_pop     (w_pop),
        .i_ready   (m_axis_tready),
        .o_valid   (m_axis_tvalid),
        .o_evt     (w_evt),
        .o_last    (m_axis_tlast)
    );

    // Pack the event fields onto the output word
    assign m_axis_tdata = {4'd0, w_evt.error_code, w_evt.tag_kind, w_evt.out_byte};
    assign m_axis_tuser = {3'd0, w_evt.end_seen, w_evt.event_res};

    // A push never lands on a full queue
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> !w_fifo_st.full)
        else $error("bundle pushed into full queue");

    // The end acknowledgement is always the only, hence last, event of its word
    a_end_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser[4]) |-> m_axis_tlast)
        else $error("end acknowledgement not marked last");

    // Tag kind is carried only by the tag-done event
    a_kind_only_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser[3:0] != EV_TAG_DONE) |-> m_axis_tdata[9:8] == TK_NONE)
        else $error("tag kind on wrong event");

    // Popping needs a bundle in the queue
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> !w_fifo_st.empty)
        else $error("pop from empty queue");

endmodule

/* rtl/mtt_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtt_front
// Accepts input words, runs the tokenizer state and builds the event bundle.
// ----------------------------------------------------------------------------
module mtt_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic              i_kind,
    input  logic [7:0]        i_byte,
    input  mtt_pkg::t_fifo_st i_fifo_st,
    output logic              o_push,
    output mtt_pkg::t_bundle  o_bundle
);
    import mtt_pkg::*;

    localparam logic [2:0] ROLE_NONE   = 3'd0;
    localparam logic [2:0] ROLE_TAG    = 3'd1;
    localparam logic [2:0] ROLE_NAME   = 3'd2;
    localparam logic [2:0] ROLE_VALUE  = 3'd3;
    localparam logic [2:0] ROLE_STRING = 3'd4;

    localparam logic [1:0] Q_NONE   = 2'd0;
    localparam logic [1:0] Q_DOUBLE = 2'd1;
    localparam logic [1:0] Q_SINGLE = 2'd2;

    localparam logic [7:0] CH_LT    = 8'd60;
    localparam logic [7:0] CH_GT    = 8'd62;
    localparam logic [7:0] CH_SLASH = 8'd47;
    localparam logic [7:0] CH_COLON = 8'd58;
    localparam logic [7:0] CH_EQ    = 8'd61;
    localparam logic [7:0] CH_BSL   = 8'd92;
    localparam logic [7:0] CH_DQ    = 8'd34;
    localparam logic [7:0] CH_SQ    = 8'd39;
    localparam logic [7:0] CH_SPACE = 8'd32;
    localparam logic [7:0] CH_TAB   = 8'd9;
    localparam logic [7:0] CH_CR    = 8'd13;

    typedef struct packed {
        logic       inside_tag;
        logic       in_quotes;
        logic       escape_active;
        logic       gap_after_name;
        logic [1:0] open_quote_char;
        logic [2:0] word_role;
        logic [1:0] current_tag_kind;
        logic       word_has_bytes;
        logic       tag_named;
        logic       name_pending;
        logic       attrs_seen;
        logic       failed;
    } t_tok_state;

    function automatic t_bundle push(t_bundle b, t_evt e);
        t_bundle r;
        r = b;
        if (b.cnt < CNT_W'(MAX_RES)) begin
            r.ev[b.cnt[SUB_W-1:0]] = e;
            r.cnt = b.cnt + CNT_W'(1);
        end
        return r;
    endfunction

    t_tok_state r_st, n_st;
    t_bundle    w_bundle;
    logic       w_accept;

    assign o_ready  = !i_fifo_st.full;
    assign w_accept = i_valid && o_ready;

    always_comb begin
        t_tok_state s;
        t_bundle    b;
        logic       clr_esc;
        logic [1:0] qcode;
        logic [7:0] c;
        c       = i_byte;
        s       = r_st;
        b       = '0;
        clr_esc = 1'b1;
        qcode   = (c == CH_DQ) ? Q_DOUBLE : ((c == CH_SQ) ? Q_SINGLE : Q_NONE);
        if (i_kind == KIND_END) begin
            b = push(b, mk_evt(EV_TEXT_END, 8'd0, TK_NONE, ERR_BAD_CHAR, 1'b1));
            s = '0;
        end else if (!r_st.failed) begin
            if (c == CH_LT) begin
                if (s.current_tag_kind != TK_NONE) begin
                    s.failed = 1'b1; clr_esc = 1'b0;
                    b = push(b, mk_evt(EV_ERROR, 8'd0, TK_NONE, ERR_BAD_CHAR, 1'b0));
                end else begin
                    if (s.word_has_bytes) begin
                        b = push(b, mk_evt(EV_TEXT_END, 8'd0, TK_NONE, ERR_BAD_CHAR, 1'b0));
                        s.word_has_bytes = 1'b0;
                    end
                    s.word_role        = ROLE_TAG;
                    s.current_tag_kind = TK_OPEN;
                    s.inside_tag       = 1'b1;
                    s.tag_named        = 1'b0;
                end
            end else if (!s.inside_tag) begin
                b = push(b, mk_evt(EV_APPEND, c, TK_NONE, ERR_BAD_CHAR, 1'b0));
                s.word_has_bytes = 1'b1;
            end else if (c == CH_BSL) begin
                if (!s.in_quotes || s.current_tag_kind == TK_SELF) begin
                    s.failed = 1'b1; clr_esc = 1'b0;
                    b = push(b, mk_evt(EV_ERROR, 8'd0, TK_NONE, ERR_BAD_CHAR, 1'b0));
                end else begin
                    s.escape_active = !s.escape_active;
                    if (s.escape_active) begin
                        clr_esc = 1'b0;
                    end else begin
                        b = push(b, mk_evt(EV_APPEND, c, TK_NONE, ERR_BAD_CHAR, 1'b0));
                        s.word_has_bytes = 1'b1;
                    end
                end
            end else if (qcode != Q_NONE &&
                         (s.open_quote_char == Q_NONE || s.open_quote_char == qcode)) begin
                if (s.current_tag_kind == TK_SELF) begin
                    s.failed = 1'b1; clr_esc = 1'b0;
                    b = push(b, mk_evt(EV_ERROR, 8'd0, TK_NONE, ERR_BAD_CHAR, 1'b0));
                end else if (s.in_quotes) begin
                    if (s.escape_active) begin
                        b = push(b, mk_evt(EV_APPEND, c, TK_NONE, ERR_BAD_CHAR, 1'b0));
                        s.word_has_bytes = 1'b1;
                    end else begin
                        s.in_quotes = 1'b0;
                        if (!s.name_pending) begin
                            s.failed = 1'b1; clr_esc = 1'b0;
                            b = push(b, mk_evt(EV_ERROR, 8'd0, TK_NONE, ERR_BAD_CHAR, 1'b0));
                        end else begin
                            b = push(b, mk_evt(EV_PAIR, 8'd0, TK_NONE, ERR_BAD_CHAR, 1'b0));
                            s.attrs_seen      = 1'b1;
                            s.word_has_bytes  = 1'b0;
                            s.name_pending    = 1'b0;
                            s.word_role       = ROLE_NONE;
                            s.open_quote_char = Q_NONE;
                        end
                    end
                end else if (s.word_role != ROLE_VALUE) begin
                    s.failed = 1'b1; clr_esc = 1'b0;
                    b = push(b, mk_evt(EV_ERROR, 8'd0, TK_NONE, ERR_BAD_CHAR, 1'b0));
                end else begin
                    s.in_quotes       = 1'b1;
                    s.word_role       = ROLE_STRING;
                    s.open_quote_char = qcode;
                end
            end else if (s.in_quotes) begin
                b = push(b, mk_evt(EV_APPEND, c, TK_NONE, ERR_BAD_CHAR, 1'b0));
                s.word_has_bytes = 1'b1;
            end else if (c == CH_SLASH) begin
                if (s.current_tag_kind != TK_OPEN) begin
                    s.failed = 1'b1; clr_esc = 1'b0;
                    b = push(b, mk_evt(EV_ERROR, 8'd0, TK_NONE, ERR_BAD_CHAR, 1'b0));
                end else begin
                    s.current_tag_kind = s.tag_named ? TK_SELF : TK_CLOSE;
                end
            end else if (c == CH_GT) begin
                // tag completion leaves the escape flag as it is
                clr_esc = 1'b0;
                if (s.current_tag_kind == TK_NONE) begin
                    s.failed = 1'b1;
                    b = push(b, mk_evt(EV_ERROR, 8'd0, TK_NONE, ERR_BAD_CHAR, 1'b0));
                end else if (!s.tag_named && !s.word_has_bytes) begin
                    s.failed = 1'b1;
                    b = push(b, mk_evt(EV_ERROR, 8'd0, TK_NONE, ERR_NO_TAG_NAME, 1'b0));
                end else begin
                    if (s.tag_named) begin
                        if (s.word_has_bytes) begin
                            if (!s.name_pending) begin
                                b = push(b, mk_evt(EV_NAME_ONLY, 8'd0, TK_NONE,
                                                   ERR_BAD_CHAR, 1'b0));
                            end else begin
                                b = push(b, mk_evt(EV_PAIR, 8'd0, TK_NONE,
                                                   ERR_BAD_CHAR, 1'b0));
                                s.name_pending = 1'b0;
                            end
                            s.attrs_seen     = 1'b1;
                            s.word_has_bytes = 1'b0;
                        end
                    end else begin
                        b = push(b, mk_evt(EV_TAG_NAME, 8'd0, TK_NONE, ERR_BAD_CHAR, 1'b0));
                        s.tag_named      = 1'b1;
                        s.word_has_bytes = 1'b0;
                    end
                    if (s.name_pending) begin
                        b = push(b, mk_evt(EV_PENDING_EMPTY, 8'd0, TK_NONE,
                                           ERR_BAD_CHAR, 1'b0));
                        s.name_pending = 1'b0;
                        s.attrs_seen   = 1'b1;
                    end
                    if (s.current_tag_kind == TK_CLOSE && s.attrs_seen) begin
                        s.failed = 1'b1;
                        b = push(b, mk_evt(EV_ERROR, 8'd0, TK_NONE, ERR_CLOSE_ATTRS, 1'b0));
                    end else begin
                        b = push(b, mk_evt(EV_TAG_DONE, 8'd0, s.current_tag_kind,
                                           ERR_BAD_CHAR, 1'b0));
                        s.word_has_bytes   = 1'b0;
                        s.word_role        = ROLE_NONE;
                        s.current_tag_kind = TK_NONE;
                        s.inside_tag       = 1'b0;
                        s.tag_named        = 1'b0;
                        s.attrs_seen       = 1'b0;
                    end
                end
            end else if (c == CH_COLON) begin
                if (s.current_tag_kind == TK_SELF || !s.word_has_bytes || s.tag_named) begin
                    s.failed = 1'b1; clr_esc = 1'b0;
                    b = push(b, mk_evt(EV_ERROR, 8'd0, TK_NONE, ERR_BAD_CHAR, 1'b0));
                end else begin
                    b = push(b, mk_evt(EV_TAG_NAME, 8'd0, TK_NONE, ERR_BAD_CHAR, 1'b0));
                    s.tag_named      = 1'b1;
                    s.word_has_bytes = 1'b0;
                    s.word_role      = ROLE_NAME;
                end
            end else if (c == CH_EQ) begin
                if (s.current_tag_kind == TK_SELF || s.word_role != ROLE_NAME ||
                    s.name_pending) begin
                    s.failed = 1'b1; clr_esc = 1'b0;
                    b = push(b, mk_evt(EV_ERROR, 8'd0, TK_NONE, ERR_BAD_CHAR, 1'b0));
                end else begin
                    b = push(b, mk_evt(EV_PENDING_NAME, 8'd0, TK_NONE, ERR_BAD_CHAR, 1'b0));
                    s.name_pending   = 1'b1;
                    s.word_has_bytes = 1'b0;
                    s.word_role      = ROLE_VALUE;
                    s.gap_after_name = 1'b0;
                end
            end else if (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR)) begin
                if (s.word_role != ROLE_NONE && s.word_has_bytes) begin
                    if (s.current_tag_kind == TK_SELF) begin
                        s.failed = 1'b1; clr_esc = 1'b0;
                        b = push(b, mk_evt(EV_ERROR, 8'd0, TK_NONE, ERR_BAD_CHAR, 1'b0));
                    end else if (s.word_role == ROLE_TAG) begin
                        if (s.tag_named) begin
                            s.failed = 1'b1; clr_esc = 1'b0;
                            b = push(b, mk_evt(EV_ERROR, 8'd0, TK_NONE, ERR_BAD_CHAR, 1'b0));
                        end else begin
                            b = push(b, mk_evt(EV_TAG_NAME, 8'd0, TK_NONE,
                                               ERR_BAD_CHAR, 1'b0));
                            s.tag_named      = 1'b1;
                            s.word_has_bytes = 1'b0;
                            s.word_role      = ROLE_NONE;
                        end
                    end else if (s.word_role == ROLE_VALUE) begin
                        if (!s.name_pending) begin
                            s.failed = 1'b1; clr_esc = 1'b0;
                            b = push(b, mk_evt(EV_ERROR, 8'd0, TK_NONE,
                                               ERR_BAD_TOKEN, 1'b0));
                        end else begin
                            b = push(b, mk_evt(EV_PAIR, 8'd0, TK_NONE, ERR_BAD_CHAR, 1'b0));
                            s.attrs_seen     = 1'b1;
                            s.word_has_bytes = 1'b0;
                            s.name_pending   = 1'b0;
                            s.word_role      = ROLE_NONE;
                        end
                    end else if (s.word_role == ROLE_NAME) begin
                        s.gap_after_name = 1'b1;
                    end
                end
            end else begin
                if (s.current_tag_kind == TK_SELF) begin
                    s.failed = 1'b1; clr_esc = 1'b0;
                    b = push(b, mk_evt(EV_ERROR, 8'd0, TK_NONE, ERR_BAD_CHAR, 1'b0));
                end else if (s.gap_after_name) begin
                    s.gap_after_name = 1'b0;
                    if (s.word_has_bytes) begin
                        b = push(b, mk_evt(EV_NAME_ONLY, 8'd0, TK_NONE, ERR_BAD_CHAR, 1'b0));
                        s.attrs_seen     = 1'b1;
                        s.word_has_bytes = 1'b0;
                    end
                    b = push(b, mk_evt(EV_APPEND, c, TK_NONE, ERR_BAD_CHAR, 1'b0));
                    s.word_has_bytes = 1'b1;
                    s.word_role      = ROLE_NAME;
                end else begin
                    b = push(b, mk_evt(EV_APPEND, c, TK_NONE, ERR_BAD_CHAR, 1'b0));
                    s.word_has_bytes = 1'b1;
                    if (s.word_role == ROLE_NONE) begin
                        s.word_role = ROLE_NAME;
                    end
                end
            end
            if (clr_esc) begin
                s.escape_active = 1'b0;
            end
        end
        n_st     = s;
        w_bundle = b;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= '0;
        end else if (w_accept) begin
            r_st <= n_st;
        end
    end

    // Words that cause no event are dropped here
    assign o_push   = w_accept && (w_bundle.cnt != '0);
    assign o_bundle = w_bundle;

endmodule

/* rtl/mtt_fifo.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtt_fifo
// Short queue of event bundles between the front and the back.
// ----------------------------------------------------------------------------
module mtt_fifo #(
    parameter int DEPTH = mtt_pkg::FIFO_DEPTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  mtt_pkg::t_bundle  i_wdata,
    input  logic              i_pop,
    output mtt_pkg::t_bundle  o_head,
    output mtt_pkg::t_fifo_st o_st
);
    import mtt_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_FW = $clog2(DEPTH + 1);

    t_bundle           r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr, r_rd_ptr;
    logic [CNT_FW-1:0] r_count;
    logic              w_do_push, w_do_pop;

    assign o_st.full  = (r_count == CNT_FW'(DEPTH));
    assign o_st.empty = (r_count == '0);
    assign w_do_push  = i_push && !o_st.full;
    assign w_do_pop   = i_pop && !o_st.empty;
    assign o_head     = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_wr_ptr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (w_do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
            end
            case ({w_do_push, w_do_pop})
                2'b10:   r_count <= r_count + CNT_FW'(1);
                2'b01:   r_count <= r_count - CNT_FW'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

/* rtl/mtt_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtt_back
// Unpacks the head bundle into single events through an output register.
// ----------------------------------------------------------------------------
module mtt_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  mtt_pkg::t_bundle  i_head,
    input  mtt_pkg::t_fifo_st i_fifo_st,
    output logic              o_pop,
    input  logic              i_ready,
    output logic              o_valid,
    output mtt_pkg::t_evt     o_evt,
    output logic              o_last
);
    import mtt_pkg::*;

    logic [SUB_W-1:0] r_sub;
    logic             r_valid;
    t_evt             r_evt;
    logic             r_last;
    logic             w_load, w_final;

    assign w_load  = !i_fifo_st.empty && (!r_valid || i_ready);
    assign w_final = ({1'b0, r_sub} == (i_head.cnt - CNT_W'(1)));
    assign o_pop   = w_load && w_final;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sub   <= '0;
            r_valid <= 1'b0;
        end else begin
            if (w_load) begin
                r_valid <= 1'b1;
                r_sub   <= w_final ? '0 : r_sub + SUB_W'(1);
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_evt  <= i_head.ev[r_sub];
            r_last <= w_final;
        end
    end

    assign o_valid = r_valid;
    assign o_evt   = r_evt;
    assign o_last  = r_last;

endmodule
